// ----- rtl/core/art_pkg.sv -----
// Shared types, codes and constants for the acknowledgement retransmit table.
// Used by art_ctrl, art_dp and ack_retransmit_table; depends on nothing.
package art_pkg;

   // Default sizing of the table.
   localparam int ART_TABLE_DEPTH = 32;
   localparam int ART_MAX_TRIES   = 7;

   // Reset value of the pending limit register.
   localparam logic [5:0] ART_LIMIT_RESET = 6'd32;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_REGISTER = 2'd0,
      ACT_ACK      = 2'd1,
      ACT_SCAN     = 2'd2,
      ACT_NONE     = 2'd3
   } act_type;

   // Response kind codes.
   typedef enum logic [2:0] {
      KIND_REGISTERED  = 3'd0,
      KIND_DUPLICATE   = 3'd1,
      KIND_FULL        = 3'd2,
      KIND_ACK_REMOVED = 3'd3,
      KIND_ACK_UNKNOWN = 3'd4,
      KIND_ACK_MISMATCH = 3'd5,
      KIND_RESEND      = 3'd6,
      KIND_SCAN_DONE   = 3'd7
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } ctrl_state_type;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic [31:0] message_id;
      logic [31:0] client_id;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] send_time;
      logic [2:0]  retries;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic adv;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit_req;
      logic walk_done;
      logic out_free;
   } sts_type;

   // Resend delay in ms for a retry index; indexes past the list use the last delay.
   function automatic logic [31:0] delay_ms(input logic [2:0] idx);
      logic [31:0] d;
      case (idx)
         3'd0: d = 32'd125;
         3'd1: d = 32'd250;
         3'd2: d = 32'd500;
         3'd3: d = 32'd750;
         3'd4: d = 32'd1000;
         3'd5: d = 32'd2000;
         default: d = 32'd5000;
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/core/ack_retransmit_table.sv -----
// Top level of the acknowledgement retransmit table.
// Depends on art_pkg, art_ctrl and art_dp.
//
//  Channel  | Direction | Handshake            | Payload
//  req_     | in        | req_valid/req_stall  | action, message id, client id, peer, time
//  rsp_     | out       | rsp_valid/rsp_stall  | kind, message id, client id, retries, last
//  csr_     | in        | csr_write_enable     | pending limit (6 bits)
//
// Each transaction walks every table slot through the entry memory's read port,
// one slot per cycle unless a resend waits on a stalled output; no new item is
// accepted until the final result of the current one enters the output register.
// Action 3 is accepted while idle and gives no result.
// A resend waiting on a stalled output holds the walk until it is taken.
// Reset is synchronous; it empties the table and sets the limit to 32.
module ack_retransmit_table
   import art_pkg::*;
#(
   parameter int TABLE_DEPTH = ART_TABLE_DEPTH,
   parameter int MAX_TRIES   = ART_MAX_TRIES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_message_id,
   input  logic [31:0] req_client_id,
   input  logic [31:0] req_peer_ip,
   input  logic [15:0] req_peer_port,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_out_message_id,
   output logic [31:0] rsp_out_client_id,
   output logic [2:0]  rsp_retry_count,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   // Controller.
   art_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_action(req_action),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   art_dp #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_TRIES  (MAX_TRIES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_message_id    (req_message_id),
      .req_client_id     (req_client_id),
      .req_peer_ip       (req_peer_ip),
      .req_peer_port     (req_peer_port),
      .req_now_ms        (req_now_ms),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_message_id(rsp_out_message_id),
      .rsp_out_client_id (rsp_out_client_id),
      .rsp_retry_count   (rsp_retry_count),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- rtl/core/art_ctrl.sv -----
// Controller state machine of the acknowledgement retransmit table.
// Depends on art_pkg; drives the datapath art_dp through command signals.
module art_ctrl
   import art_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic [1:0] req_action,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && (act_type'(req_action) != ACT_NONE)) state_in = S_WALK;
         end
         S_WALK: begin
            if (sts.walk_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_WALK: begin
            // Hold the walk while a resend waits for room in the output register.
            cmd.adv = !sts.walk_done && !(sts.emit_req && !sts.out_free);
         end
         S_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: cmd = '0;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The final result is only issued when the output register can take it.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free) else $error("final result issued into a full output");

   // The walk never advances outside the walk state.
   a_adv_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.adv |-> (state_ff == S_WALK)) else $error("walk advanced outside walk state");

   // A transaction is only loaded while idle.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == S_IDLE) && !req_stall) else $error("load while busy");

endmodule

// ----- rtl/core/art_dp.sv -----
// Datapath of the acknowledgement retransmit table: entry memory, valid bits,
// pending count, slot walk and output register. Depends on art_pkg.
module art_dp
   import art_pkg::*;
#(
   parameter int TABLE_DEPTH = ART_TABLE_DEPTH,
   parameter int MAX_TRIES   = ART_MAX_TRIES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_message_id,
   input  logic [31:0] req_client_id,
   input  logic [31:0] req_peer_ip,
   input  logic [15:0] req_peer_port,
   input  logic [31:0] req_now_ms,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_out_message_id,
   output logic [31:0] rsp_out_client_id,
   output logic [2:0]  rsp_retry_count,
   output logic        rsp_last
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Latched transaction.
   act_type     act_ff;
   logic [31:0] mid_ff, cid_ff, ip_ff, now_ff;
   logic [15:0] port_ff;

   logic [5:0]             limit_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [5:0]             count_ff, count_in;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   logic [CW-1:0] rd_addr_ff;
   logic          chk_vld_ff;
   logic [AW-1:0] chk_slot_ff;
   logic          hit_ff, hit_match_ff;
   logic [AW-1:0] hit_slot_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    kind_ff;
   logic [31:0] omid_ff, ocid_ff;
   logic [2:0]  retry_ff;
   logic        last_ff;

   logic          rd_more, chk_live, retry_drop, emit_req, step, load_out;
   logic [31:0]   elapsed;
   logic          free_found, full;
   logic [AW-1:0] free_slot;
   kind_type      fin_kind;
   logic [31:0]   fin_mid;
   logic          do_alloc, do_remove;
   logic          we;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [2:0]    retry_next;

   // Walk and check-stage status.
   assign rd_more    = rd_addr_ff < CW'(TABLE_DEPTH);
   assign chk_live   = chk_vld_ff && valid_ff[chk_slot_ff];
   assign elapsed    = now_ff - rd_data_ff.send_time;
   assign retry_drop = rd_data_ff.retries >= 3'(MAX_TRIES);
   assign retry_next = rd_data_ff.retries + 3'd1;
   assign emit_req   = (act_ff == ACT_SCAN) && chk_live && !retry_drop &&
                       (elapsed > delay_ms(rd_data_ff.retries));
   assign step       = cmd.adv && chk_vld_ff;

   assign sts.emit_req  = emit_req;
   assign sts.walk_done = !rd_more && !chk_vld_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = AW'(i);
         end
      end
   end

   assign full = (count_ff > limit_ff) || !free_found;

   // Final result of a transaction.
   always_comb begin
      fin_kind  = KIND_SCAN_DONE;
      fin_mid   = mid_ff;
      do_alloc  = 1'b0;
      do_remove = 1'b0;
      case (act_ff)
         ACT_REGISTER: begin
            if (hit_ff) begin
               fin_kind = KIND_DUPLICATE;
            end else if (full) begin
               fin_kind = KIND_FULL;
            end else begin
               fin_kind = KIND_REGISTERED;
               do_alloc = 1'b1;
            end
         end
         ACT_ACK: begin
            if (!hit_ff) begin
               fin_kind = KIND_ACK_UNKNOWN;
            end else if (hit_match_ff) begin
               fin_kind  = KIND_ACK_REMOVED;
               do_remove = 1'b1;
            end else begin
               fin_kind = KIND_ACK_MISMATCH;
            end
         end
         default: begin
            fin_kind = KIND_SCAN_DONE;
            fin_mid  = '0;
         end
      endcase
   end

   // Valid bits and pending count.
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (step && (act_ff == ACT_SCAN) && chk_live && retry_drop) begin
         valid_in[chk_slot_ff] = 1'b0;
         count_in = count_ff - 6'd1;
      end
      if (cmd.finish && do_alloc) begin
         valid_in[free_slot] = 1'b1;
         count_in = count_ff + 6'd1;
      end
      if (cmd.finish && do_remove) begin
         valid_in[hit_slot_ff] = 1'b0;
         count_in = count_ff - 6'd1;
      end
   end

   // Entry memory write port: retry update on resend, new entry on register.
   always_comb begin
      we      = 1'b0;
      wr_addr = chk_slot_ff;
      wr_data = rd_data_ff;
      if (step && emit_req) begin
         we              = 1'b1;
         wr_data.retries = retry_next;
      end else if (cmd.finish && do_alloc) begin
         we      = 1'b1;
         wr_addr = free_slot;
         wr_data = '{message_id: mid_ff, client_id: cid_ff, peer_ip: ip_ff,
                     peer_port: port_ff, send_time: now_ff, retries: 3'd0};
      end
   end

   // Output register next valid.
   assign load_out     = (step && emit_req) || cmd.finish;
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   // Entry memory.
   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      if (cmd.adv && rd_more) rd_data_ff <= mem[rd_addr_ff[AW-1:0]];
   end

   // Transaction capture and output payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= act_type'(req_action);
         mid_ff  <= req_message_id;
         cid_ff  <= req_client_id;
         ip_ff   <= req_peer_ip;
         port_ff <= req_peer_port;
         now_ff  <= req_now_ms;
      end
      if (step && emit_req) begin
         kind_ff  <= KIND_RESEND;
         omid_ff  <= rd_data_ff.message_id;
         ocid_ff  <= rd_data_ff.client_id;
         retry_ff <= retry_next;
         last_ff  <= 1'b0;
      end else if (cmd.finish) begin
         kind_ff  <= fin_kind;
         omid_ff  <= fin_mid;
         ocid_ff  <= '0;
         retry_ff <= '0;
         last_ff  <= 1'b1;
      end
      if (step) begin
         if (!hit_ff) begin
            hit_slot_ff  <= chk_slot_ff;
            hit_match_ff <= (rd_data_ff.peer_ip == ip_ff) &&
                            (rd_data_ff.peer_port == port_ff);
         end
      end
   end

   // Control state: walk pointers, search hit, table bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ART_LIMIT_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         rd_addr_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         chk_slot_ff  <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) limit_ff <= csr_write_data;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            rd_addr_ff <= '0;
            chk_vld_ff <= 1'b0;
            hit_ff     <= 1'b0;
         end else if (cmd.adv) begin
            chk_vld_ff  <= rd_more;
            chk_slot_ff <= rd_addr_ff[AW-1:0];
            if (rd_more) rd_addr_ff <= rd_addr_ff + CW'(1);
            if (chk_vld_ff && (act_ff != ACT_SCAN) && chk_live &&
                (rd_data_ff.message_id == mid_ff)) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_out_message_id = omid_ff;
   assign rsp_out_client_id  = ocid_ff;
   assign rsp_retry_count    = retry_ff;
   assign rsp_last           = last_ff;

   // The pending count tracks occupied slots and never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 6'(TABLE_DEPTH)) else $error("pending count beyond table depth");

   // A resend never reads a slot whose valid bit is clear.
   a_resend_valid: assert property (@(posedge clock) disable iff (reset)
      (step && emit_req) |-> valid_ff[chk_slot_ff]) else $error("resend of empty slot");

   // A stalled response stays valid and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable({kind_ff, omid_ff, ocid_ff, retry_ff, last_ff})))
      else $error("stalled response changed");

endmodule
